>>> hw/rtl/keyed_slot_table_lru_defines.svh
// Assertion macros for the keyed slot table checker
`ifndef KEYED_SLOT_TABLE_LRU_DEFINES_SVH
`define KEYED_SLOT_TABLE_LRU_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define KSTL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define KSTL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/kstl_pkg.sv
// Package: sizes, codes, state type and slot store structs of the keyed slot table
`default_nettype none

package kstl_pkg;

    localparam int TABLE_ENTRIES = 2;
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SLOT_W  = 4;
    localparam int START_W = SLOT_W + 1;
    localparam int KEY_W   = 32;
    localparam int STAMP_W = 32;
    localparam int ID_W    = 8;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;

    localparam logic [OP_W-1:0] OP_PREPARE = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OP_W-1:0] OP_ITERATE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    localparam logic [STAT_W-1:0] STAT_HIT       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NEW       = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EVICT     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DELETED   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_DEL_EMPTY = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd5;
    localparam logic [STAT_W-1:0] STAT_END       = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_OUT
    } kstl_state_t;

    typedef struct packed {
        logic               fill;
        logic               touch;
        logic               clear;
        logic [IDX_W-1:0]   idx;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    id;
    } slot_wr_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    id;
    } slot_rd_t;

endpackage

`default_nettype wire

>>> hw/rtl/kstl_req_if.sv
// Request channel: one item per operation
`default_nettype none

interface kstl_req_if import kstl_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   freq_key;
    logic [STAMP_W-1:0] now;
    logic [SLOT_W-1:0]  slot_in;
    logic               from_start;

    modport source (
        output valid, op, freq_key, now, slot_in, from_start,
        input  ready
    );

    modport sink (
        input  valid, op, freq_key, now, slot_in, from_start,
        output ready
    );

endinterface

`default_nettype wire

>>> hw/rtl/kstl_rsp_if.sv
// Response channel: one item per answered operation
`default_nettype none

interface kstl_rsp_if import kstl_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_out;
    logic [ID_W-1:0]   entry_id;

    modport source (
        output valid, status, slot_out, entry_id,
        input  ready
    );

    modport sink (
        input  valid, status, slot_out, entry_id,
        output ready
    );

endinterface

`default_nettype wire

>>> hw/rtl/kstl_slot_store.sv
// Slot store: valid bits, keys, stamps and ids, one read and one write per cycle
`default_nettype none

module kstl_slot_store import kstl_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] rd_idx,
    input  wire slot_wr_t         wr,
    output slot_rd_t              rd
);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [KEY_W-1:0]         key_reg   [TABLE_ENTRIES];
    logic [STAMP_W-1:0]       stamp_reg [TABLE_ENTRIES];
    logic [ID_W-1:0]          id_reg    [TABLE_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.fill)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
        else if (wr.clear)
        begin
            valid_reg[wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.fill)
        begin
            key_reg[wr.idx] <= wr.key;
            id_reg[wr.idx]  <= wr.id;
        end
        if (wr.fill || wr.touch)
        begin
            stamp_reg[wr.idx] <= wr.stamp;
        end
    end

    assign rd.valid = valid_reg[rd_idx];
    assign rd.key   = key_reg[rd_idx];
    assign rd.stamp = stamp_reg[rd_idx];
    assign rd.id    = id_reg[rd_idx];

endmodule

`default_nettype wire

>>> hw/rtl/keyed_slot_table_lru.sv
// Top level: keyed slot table with least-recently-used replacement
//
// A small table of TABLE_ENTRIES slots keyed by a 32-bit frequency in Hz. Each
// request gives exactly one response; op code 3 is taken and dropped without one.
// A sequencer walks the slots one per cycle through a single key-equal and
// stamp-less-than comparator: prepare scans to a key hit, else through all slots
// and fills a free or the least-recently-used slot; delete reads its slot only,
// none beyond the table; iterate scans from its start to a valid slot or the end.
// Ready is high only between requests. The response sits in an output register,
// so a new request is taken while the previous response still waits; a request
// finishing while that register is still full waits in its last cycle.
`default_nettype none

module keyed_slot_table_lru import kstl_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kstl_req_if.sink   req,
    kstl_rsp_if.source rsp
);

    kstl_state_t         state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [STAMP_W-1:0]  now_reg, now_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [STAMP_W-1:0]  oldest_reg, oldest_next;
    logic [IDX_W-1:0]    victim_reg, victim_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;

    slot_wr_t            wr;
    slot_rd_t            rd;
    logic                key_eq;
    logic                older;
    logic                last;
    logic                out_free;
    logic                del_ok;
    logic [START_W-1:0]  start;
    logic                start_ok;
    logic [IDX_W-1:0]    fill_idx;

    kstl_slot_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (idx_reg),
        .wr     (wr),
        .rd     (rd)
    );

    assign key_eq   = rd.valid && (rd.key == key_reg);
    assign older    = rd.valid && (rd.stamp < oldest_reg);
    assign last     = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign out_free = !out_valid_reg || rsp.ready;
    assign del_ok   = ({1'b0, req.slot_in} < START_W'(TABLE_ENTRIES));
    assign start    = req.from_start ? '0 : START_W'({1'b0, req.slot_in} + START_W'(1));
    assign start_ok = (start < START_W'(TABLE_ENTRIES));
    assign fill_idx = free_found_reg ? free_idx_reg : victim_reg;

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.slot_out = out_slot_reg;
    assign rsp.entry_id = out_id_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.op)
                        OP_PREPARE: state_next = S_SCAN;
                        OP_DELETE:  state_next = del_ok ? S_SCAN : S_OUT;
                        OP_ITERATE: state_next = start_ok ? S_SCAN : S_OUT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                case (op_reg)
                    OP_PREPARE:
                    begin
                        if (key_eq)
                        begin
                            state_next = S_OUT;
                        end
                        else if (last)
                        begin
                            state_next = S_FILL;
                        end
                    end
                    OP_ITERATE:
                    begin
                        if (rd.valid || last)
                        begin
                            state_next = S_OUT;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_FILL: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        wr              = '0;
        idx_next        = idx_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        oldest_next     = oldest_reg;
        victim_next     = victim_reg;
        next_id_next    = next_id_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_id_next     = res_id_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_id_next     = out_id_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.op;
                    key_next        = req.freq_key;
                    now_next        = req.now;
                    free_found_next = 1'b0;
                    oldest_next     = '1;
                    victim_next     = '0;
                    idx_next        = '0;
                    case (req.op)
                        OP_DELETE:
                        begin
                            idx_next        = req.slot_in[IDX_W-1:0];
                            res_status_next = STAT_DEL_EMPTY;
                            res_slot_next   = req.slot_in;
                            res_id_next     = '0;
                        end
                        OP_ITERATE:
                        begin
                            idx_next        = start[IDX_W-1:0];
                            res_status_next = STAT_END;
                            res_slot_next   = '0;
                            res_id_next     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                case (op_reg)
                    OP_PREPARE:
                    begin
                        if (key_eq)
                        begin
                            wr.touch        = 1'b1;
                            wr.idx          = idx_reg;
                            wr.stamp        = now_reg;
                            res_status_next = STAT_HIT;
                            res_slot_next   = SLOT_W'(idx_reg);
                            res_id_next     = rd.id;
                        end
                        else
                        begin
                            if (!rd.valid && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = idx_reg;
                            end
                            if (older)
                            begin
                                oldest_next = rd.stamp;
                                victim_next = idx_reg;
                            end
                            if (!last)
                            begin
                                idx_next = IDX_W'(idx_reg + 1'b1);
                            end
                        end
                    end
                    OP_DELETE:
                    begin
                        res_slot_next = SLOT_W'(idx_reg);
                        if (rd.valid)
                        begin
                            wr.clear        = 1'b1;
                            wr.idx          = idx_reg;
                            res_status_next = STAT_DELETED;
                            res_id_next     = rd.id;
                        end
                        else
                        begin
                            res_status_next = STAT_DEL_EMPTY;
                            res_id_next     = '0;
                        end
                    end
                    default:
                    begin
                        if (rd.valid)
                        begin
                            res_status_next = STAT_FOUND;
                            res_slot_next   = SLOT_W'(idx_reg);
                            res_id_next     = rd.id;
                        end
                        else if (last)
                        begin
                            res_status_next = STAT_END;
                            res_slot_next   = '0;
                            res_id_next     = '0;
                        end
                        else
                        begin
                            idx_next = IDX_W'(idx_reg + 1'b1);
                        end
                    end
                endcase
            end
            S_FILL:
            begin
                wr.fill         = 1'b1;
                wr.idx          = fill_idx;
                wr.key          = key_reg;
                wr.stamp        = now_reg;
                wr.id           = next_id_reg;
                res_status_next = free_found_reg ? STAT_NEW : STAT_EVICT;
                res_slot_next   = SLOT_W'(fill_idx);
                res_id_next     = next_id_reg;
                next_id_next    = ID_W'(next_id_reg + 1'b1);
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_id_next     = res_id_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            op_reg         <= OP_NONE;
            free_found_reg <= 1'b0;
            next_id_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            op_reg         <= op_next;
            free_found_reg <= free_found_next;
            next_id_reg    <= next_id_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        now_reg        <= now_next;
        free_idx_reg   <= free_idx_next;
        oldest_reg     <= oldest_next;
        victim_reg     <= victim_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_id_reg     <= res_id_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_id_reg     <= out_id_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/kstl_checker.sv
// Port checker for the keyed slot table, bound to the top level
`default_nettype none

`include "keyed_slot_table_lru_defines.svh"

module kstl_checker import kstl_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic [OP_W-1:0]   req_op,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [STAT_W-1:0] rsp_status,
    input wire logic [SLOT_W-1:0] rsp_slot_out,
    input wire logic [ID_W-1:0]   rsp_entry_id
);

    // a stalled response keeps its item
    `KSTL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_slot_out) && $stable(rsp_entry_id), "response changed while stalled")

    // a real request drops ready in the cycle after it is taken
    `KSTL_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready && (req_op != OP_NONE), !req_ready, "ready high right after a request")

    // the unused op code is dropped and ready stays up
    `KSTL_ASSERT_NEXT(a_drop_unused, req_valid && req_ready && (req_op == OP_NONE), req_ready, "unused op code stalled the block")

    `KSTL_ASSERT_NOW(a_status_range, rsp_valid, rsp_status <= STAT_END, "status code out of range")

    `KSTL_ASSERT_NOW(a_end_zero, rsp_valid && (rsp_status == STAT_END), (rsp_slot_out == '0) && (rsp_entry_id == '0), "end of walk carries a slot or id")

endmodule

bind keyed_slot_table_lru kstl_checker u_kstl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_op       (req.op),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_status   (rsp.status),
    .rsp_slot_out (rsp.slot_out),
    .rsp_entry_id (rsp.entry_id)
);

`default_nettype wire
